/* hw/rtl/utf8wf_pkg.sv */
// shared types and constants of the utf-8 well-formedness checker
`default_nettype none
package utf8wf_pkg;

  // register map
  localparam int unsigned ADDR_BITS = 3;
  localparam int unsigned DATA_BITS = 32;
  localparam logic [ADDR_BITS-1:0] REG_MAX_LENGTH = 3'h0;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;

  // byte pattern masks
  localparam logic [7:0] MASK_CONT = 8'hC0;
  localparam logic [7:0] PAT_CONT  = 8'h80;
  localparam logic [7:0] MASK_TWO  = 8'hE0;
  localparam logic [7:0] PAT_TWO   = 8'hC0;
  localparam logic [7:0] MASK_THR  = 8'hF0;
  localparam logic [7:0] PAT_THR   = 8'hE0;
  localparam logic [7:0] MASK_FOUR = 8'hF8;
  localparam logic [7:0] PAT_FOUR  = 8'hF0;
  localparam logic [7:0] TERM_BYTE = 8'h00;

  // byte handed from the input register to the checker core
  typedef struct packed {
    logic       fire;
    logic [7:0] data;
  } utf8wf_issue_t;

endpackage
`default_nettype wire

/* hw/rtl/utf8_wellformed_checker_unit.sv */
// top level of the utf-8 well-formedness checker
`default_nettype none
// Checks a zero-terminated string for well-formed UTF-8, one byte per
// transfer, and gives one result (verdict and error position) per string,
// on the terminating zero byte. Throughput is one byte per cycle: a byte
// is held in the input register until the state update of the core
// consumes it; a terminator's result is then written to the result
// register, from which it can be taken. Nonzero bytes never wait on
// the result side; a terminator waits only while a previous result is
// held by a stall. Checking is lax: overlong forms and surrogates pass.
// max_length (byte address 0) sets the length limit, clipped to what
// COUNT_BITS can count.
module utf8_wellformed_checker_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_data_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_string_ok,
  output logic      [15:0]                       out_error_position,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [utf8wf_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [utf8wf_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [utf8wf_pkg::DATA_BITS-1:0]  prdata,
  output logic                                   pready
);
  import utf8wf_pkg::*;

  logic          in_full_r, in_full_nxt;
  logic [7:0]    in_data_r;
  logic          accept, slot_free;
  logic [15:0]   max_length;
  utf8wf_issue_t issue;

  // input register handshake
  assign issue.data = in_data_r;
  assign issue.fire = in_full_r && ((in_data_r != TERM_BYTE) || slot_free);
  assign in_stall   = in_full_r && !issue.fire;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    in_full_nxt = in_full_r;
    if (accept) begin
      in_full_nxt = 1'b1;
    end else if (issue.fire) begin
      in_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
    if (accept) begin
      in_data_r <= in_data_byte;
    end
  end

  // configuration registers
  utf8wf_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_length (max_length)
  );

  // checker core
  utf8wf_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .max_length         (max_length),
    .issue              (issue),
    .slot_free          (slot_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_string_ok      (out_string_ok),
    .out_error_position (out_error_position)
  );

endmodule
`default_nettype wire

/* hw/rtl/utf8wf_regs.sv */
// configuration register bank on an apb-style port
`default_nettype none
module utf8wf_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [utf8wf_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [utf8wf_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [utf8wf_pkg::DATA_BITS-1:0]  prdata,
  output logic                                   pready,
  output logic      [15:0]                       max_length
);
  import utf8wf_pkg::*;

  logic [15:0] max_length_r;
  logic        hit;

  // word decode, byte offset ignored
  assign hit = (paddr[ADDR_BITS-1:2] == REG_MAX_LENGTH[ADDR_BITS-1:2]);

  // register write on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      max_length_r <= pwdata[15:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(DATA_BITS-16){1'b0}}, max_length_r};
    end
  end

  assign pready     = 1'b1;
  assign max_length = max_length_r;

endmodule
`default_nettype wire

/* hw/rtl/utf8wf_core.sv */
// string state, per-byte classification and result register
`default_nettype none
module utf8wf_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [15:0]               max_length,
  input  wire utf8wf_pkg::utf8wf_issue_t issue,
  output logic                           slot_free,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_string_ok,
  output logic [15:0]                    out_error_position
);
  import utf8wf_pkg::*;

  localparam int unsigned WIDE = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [1:0]            pend_r, pend_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  failed_r, failed_nxt;
  logic [COUNT_BITS-1:0] fail_pos_r, fail_pos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  ok_r, ok_nxt;
  logic [15:0]           pos_r, pos_nxt;

  logic [WIDE-1:0] max_w, cnt_max_w, lim_w, count_w, fail_w;
  logic            at_limit, is_term, is_cont, good;
  logic [1:0]      pend_upd;

  // effective length limit, clipped to the counter range
  assign max_w     = WIDE'(max_length);
  assign cnt_max_w = WIDE'(CNT_MAX);
  assign lim_w     = (max_w > cnt_max_w) ? cnt_max_w : max_w;
  assign count_w   = WIDE'(count_r);
  assign fail_w    = WIDE'(fail_pos_r);
  assign at_limit  = (count_w >= lim_w);

  assign is_term   = (issue.data == TERM_BYTE);
  assign slot_free = !out_valid_r || !out_stall;

  // byte classification
  always_comb begin
    is_cont  = ((issue.data & MASK_CONT) == PAT_CONT);
    pend_upd = pend_r;
    good     = 1'b1;
    if (is_cont) begin
      good = (pend_r != 2'd0);
      if (good) begin
        pend_upd = pend_r - 2'd1;
      end
    end else begin
      good = (pend_r == 2'd0);
      if (!issue.data[7]) begin
        pend_upd = pend_r;
      end else if ((issue.data & MASK_TWO) == PAT_TWO) begin
        pend_upd = 2'd1;
      end else if ((issue.data & MASK_THR) == PAT_THR) begin
        pend_upd = 2'd2;
      end else if ((issue.data & MASK_FOUR) == PAT_FOUR) begin
        pend_upd = 2'd3;
      end else begin
        good = 1'b0;
      end
    end
  end

  // next string state and result
  always_comb begin
    pend_nxt      = pend_r;
    count_nxt     = count_r;
    failed_nxt    = failed_r;
    fail_pos_nxt  = fail_pos_r;
    ok_nxt        = ok_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (issue.fire) begin
      if (is_term) begin
        out_valid_nxt = 1'b1;
        if (failed_r) begin
          ok_nxt  = 1'b0;
          pos_nxt = fail_w[15:0];
        end else if (pend_r != 2'd0 || at_limit) begin
          ok_nxt  = 1'b0;
          pos_nxt = count_w[15:0];
        end else begin
          ok_nxt  = 1'b1;
          pos_nxt = 16'd0;
        end
        pend_nxt     = 2'd0;
        count_nxt    = '0;
        failed_nxt   = 1'b0;
        fail_pos_nxt = '0;
      end else if (!failed_r && !at_limit) begin
        pend_nxt  = pend_upd;
        count_nxt = count_r + COUNT_BITS'(1);
        if (!good) begin
          failed_nxt   = 1'b1;
          fail_pos_nxt = count_r;
        end
      end
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 2'd0;
      count_r     <= '0;
      failed_r    <= 1'b0;
      fail_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      failed_r    <= failed_nxt;
      fail_pos_r  <= fail_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ok_r  <= ok_nxt;
    pos_r <= pos_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_string_ok      = ok_r;
  assign out_error_position = pos_r;

endmodule
`default_nettype wire
